// ===== rtl/gslbd_pkg.sv =====
package gslbd_pkg;

    // Fixed sizes of the decoder.
    localparam int MaxClasses = 1024;
    localparam int MaxSeq     = 64;
    localparam int ScoreFrac  = 16;

    localparam int ClassW  = 10;
    localparam int ScoreW  = ScoreFrac + 1;
    localparam int ModeW   = 2;
    localparam int SeqLenW = 7;
    localparam int NumClsW = 11;
    localparam int AddrW   = 4;
    localparam int DataW   = 32;
    localparam int StepW   = $clog2(MaxSeq + 1);
    localparam int CountW  = $clog2(MaxClasses);

    localparam logic [ScoreW-1:0]  ProbOne     = ScoreW'(1) << ScoreFrac;
    localparam logic [ClassW-1:0]  BlankClass  = '0;
    localparam logic [SeqLenW-1:0] MaxSeqLen   = SeqLenW'(MaxSeq);
    localparam logic [NumClsW-1:0] MaxNumCls   = NumClsW'(MaxClasses);
    localparam logic [NumClsW-1:0] MinNumCls   = NumClsW'(2);

    // Reset values of the configuration registers.
    localparam logic [ModeW-1:0]   ModeReset   = '0;
    localparam logic [SeqLenW-1:0] SeqLenReset = SeqLenW'(26);
    localparam logic [NumClsW-1:0] NumClsReset = NumClsW'(1024);
    localparam logic [ClassW-1:0]  StopReset   = ClassW'(1);

    // Decode modes; code 3 is handled as the argmax mode.
    typedef logic [ModeW-1:0] mode_t;
    localparam mode_t ModeCollapse = 2'd0;
    localparam mode_t ModeStop     = 2'd1;
    localparam mode_t ModeArgmax   = 2'd2;

    // Register indexes on the configuration port.
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t RegMode   = 2'd0;
    localparam reg_idx_t RegSeqLen = 2'd1;
    localparam reg_idx_t RegNumCls = 2'd2;
    localparam reg_idx_t RegStop   = 2'd3;

endpackage

// ===== rtl/greedy_sequence_label_decoder_unit.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_class_id, s_score
// m_        out        m_valid / m_ready  m_char_valid, m_char_id, m_seq_end, m_seq_prob
// apb       in         psel / penable     paddr, pwdata, pwrite -> prdata, pready
//
// One transfer is taken per cycle unless the result stalls; an item is held in the input
// register and its result in the result register. The 17x17 product update and the row
// maximum compare sit between the two, so one item per cycle is sustained while results
// are taken. Reset (aresetn low at a clock edge) sets all control state to its reset values;
// any register write restarts the current sequence. A stalled result holds the pipe, and the
// input register is refilled in the same cycle in which its item moves on.
module greedy_sequence_label_decoder_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gslbd_pkg::ClassW-1:0]    s_class_id,
    input  logic [gslbd_pkg::ScoreW-1:0]    s_score,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_char_valid,
    output logic [gslbd_pkg::ClassW-1:0]    m_char_id,
    output logic                            m_seq_end,
    output logic [gslbd_pkg::ScoreW-1:0]    m_seq_prob,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gslbd_pkg::AddrW-1:0]     paddr,
    input  logic [gslbd_pkg::DataW-1:0]     pwdata,
    output logic [gslbd_pkg::DataW-1:0]     prdata,
    output logic                            pready
);
    import gslbd_pkg::*;

    // Configuration registers.
    mode_t                mode_reg;
    logic [SeqLenW-1:0]   seq_len_reg;
    logic [NumClsW-1:0]   num_cls_reg;
    logic [ClassW-1:0]    stop_reg;

    // Input register.
    logic                 in_vld_reg;
    logic [ClassW-1:0]    in_cls_reg;
    logic [ScoreW-1:0]    in_score_reg;

    // Sequence state.
    logic [StepW-1:0]     step_reg,  step_next;
    logic [CountW-1:0]    count_reg, count_next;
    logic [ScoreW-1:0]    best_score_reg, best_score_next;
    logic [CountW-1:0]    best_class_reg, best_class_next;
    logic [ClassW-1:0]    prev_reg,  prev_next;
    logic                 stopped_reg, stopped_next;
    logic [ScoreW-1:0]    prob_reg,  prob_next;

    // Result register.
    logic                 out_vld_reg, out_vld_next;
    logic                 out_cv_reg,  out_cv_next;
    logic [ClassW-1:0]    out_cid_reg, out_cid_next;
    logic                 out_end_reg, out_end_next;
    logic [ScoreW-1:0]    out_prob_reg, out_prob_next;

    logic                 cfg_wr;
    reg_idx_t             cfg_idx;
    logic                 advance;
    logic [SeqLenW-1:0]   len;
    logic [NumClsW-1:0]   nc;
    logic [ScoreW-1:0]    sc;
    logic [ScoreW-1:0]    mul_score;
    logic [2*ScoreW-1:0]  mul_full;
    logic [ScoreW-1:0]    mul_prob;
    logic                 do_mul;
    logic                 emit;
    logic [ClassW-1:0]    cid;
    logic                 step_inc;
    logic [StepW:0]       step_plus;
    logic                 seq_done;
    logic                 row_end;
    logic                 fresh;
    logic [ScoreW-1:0]    row_best_score;
    logic [CountW-1:0]    row_best_class;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        case (cfg_idx)
            RegMode:   prdata = DataW'(mode_reg);
            RegSeqLen: prdata = DataW'(seq_len_reg);
            RegNumCls: prdata = DataW'(num_cls_reg);
            RegStop:   prdata = DataW'(stop_reg);
            default:   prdata = '0;
        endcase
    end

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    // Clamped operands.
    assign len = (seq_len_reg == '0) ? SeqLenW'(1)
               : (seq_len_reg > MaxSeqLen) ? MaxSeqLen : seq_len_reg;
    assign nc  = (num_cls_reg < MinNumCls) ? MinNumCls
               : (num_cls_reg > MaxNumCls) ? MaxNumCls : num_cls_reg;
    assign sc  = (in_score_reg > ProbOne) ? ProbOne : in_score_reg;

    // Running maximum of the current row, including this score; ties keep the earlier class.
    always_comb begin
        if (count_reg == '0 || sc > best_score_reg) begin
            row_best_score = sc;
            row_best_class = count_reg;
        end else begin
            row_best_score = best_score_reg;
            row_best_class = best_class_reg;
        end
    end

    assign row_end = ({1'b0, count_reg} + NumClsW'(1)) >= nc;
    assign fresh   = (step_reg == '0) || (in_cls_reg != prev_reg);

    always_comb begin
        emit            = 1'b0;
        cid             = '0;
        do_mul          = 1'b0;
        mul_score       = sc;
        step_inc        = 1'b1;
        count_next      = count_reg;
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        prev_next       = prev_reg;
        stopped_next    = stopped_reg;
        case (mode_reg)
            ModeCollapse: begin
                prev_next = in_cls_reg;
                if (fresh && in_cls_reg != BlankClass && {1'b0, in_cls_reg} < nc) begin
                    emit   = 1'b1;
                    cid    = in_cls_reg;
                    do_mul = 1'b1;
                end
            end
            ModeStop: begin
                if (!stopped_reg) begin
                    if (in_cls_reg == stop_reg) begin
                        stopped_next = 1'b1;
                    end else if ({1'b0, in_cls_reg} < nc) begin
                        emit   = 1'b1;
                        cid    = in_cls_reg;
                        do_mul = 1'b1;
                    end
                end
            end
            default: begin
                best_score_next = row_best_score;
                best_class_next = row_best_class;
                mul_score       = row_best_score;
                step_inc        = row_end;
                if (row_end) begin
                    count_next = '0;
                    if (!stopped_reg) begin
                        do_mul = 1'b1;
                        if (ClassW'(row_best_class) == stop_reg) begin
                            stopped_next = 1'b1;
                        end else begin
                            emit = 1'b1;
                            cid  = ClassW'(row_best_class);
                        end
                    end
                end else begin
                    count_next = count_reg + CountW'(1);
                end
            end
        endcase
    end

    // Product update; both factors are at most one, so the result fits ScoreW bits.
    assign mul_full = prob_reg * mul_score;
    assign mul_prob = mul_full[ScoreFrac +: ScoreW];

    assign step_plus = {1'b0, step_reg} + (StepW + 1)'(1);
    assign seq_done  = step_inc && (step_plus >= (StepW + 1)'(len));

    always_comb begin
        prob_next = do_mul ? mul_prob : prob_reg;
        step_next = step_inc ? step_plus[StepW-1:0] : step_reg;
    end

    always_comb begin
        out_vld_next  = out_vld_reg && !m_ready;
        out_cv_next   = out_cv_reg;
        out_cid_next  = out_cid_reg;
        out_end_next  = out_end_reg;
        out_prob_next = out_prob_reg;
        if (advance) begin
            out_vld_next  = emit || seq_done;
            out_cv_next   = emit;
            out_cid_next  = cid;
            out_end_next  = seq_done;
            out_prob_next = seq_done ? prob_next : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= ModeReset;
            seq_len_reg <= SeqLenReset;
            num_cls_reg <= NumClsReset;
            stop_reg    <= StopReset;
        end else if (cfg_wr) begin
            case (cfg_idx)
                RegMode:   mode_reg    <= pwdata[ModeW-1:0];
                RegSeqLen: seq_len_reg <= pwdata[SeqLenW-1:0];
                RegNumCls: num_cls_reg <= pwdata[NumClsW-1:0];
                RegStop:   stop_reg    <= pwdata[ClassW-1:0];
                default: ;
            endcase
        end
    end

    // The item that closes a sequence leaves the state as after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr || (advance && seq_done)) begin
            step_reg       <= '0;
            count_reg      <= '0;
            best_score_reg <= '0;
            best_class_reg <= '0;
            prev_reg       <= '0;
            stopped_reg    <= 1'b0;
            prob_reg       <= ProbOne;
        end else if (advance) begin
            step_reg       <= step_next;
            count_reg      <= count_next;
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            prev_reg       <= prev_next;
            stopped_reg    <= stopped_next;
            prob_reg       <= prob_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cls_reg   <= s_class_id;
            in_score_reg <= s_score;
        end
        out_cv_reg   <= out_cv_next;
        out_cid_reg  <= out_cid_next;
        out_end_reg  <= out_end_next;
        out_prob_reg <= out_prob_next;
    end

    assign m_valid      = out_vld_reg;
    assign m_char_valid = out_cv_reg;
    assign m_char_id    = out_cid_reg;
    assign m_seq_end    = out_end_reg;
    assign m_seq_prob   = out_prob_reg;

endmodule

// ===== rtl/gslbd_checker.sv =====
module gslbd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_char_valid,
    input logic [gslbd_pkg::ClassW-1:0]  m_char_id,
    input logic                          m_seq_end,
    input logic [gslbd_pkg::ScoreW-1:0]  m_seq_prob
);
    import gslbd_pkg::*;

    // Every result either emits a class or closes a sequence.
    a_result_content: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_valid || m_seq_end))
        else $error("result carries neither a class nor a sequence end");

    a_cid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_char_valid) |-> (m_char_id == '0))
        else $error("class id not zero on a result without a class");

    a_prob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_seq_end) |-> (m_seq_prob == '0))
        else $error("sequence product not zero before the sequence end");

    a_prob_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_seq_prob <= ProbOne))
        else $error("sequence product above one");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_char_valid) && $stable(m_char_id)
            && $stable(m_seq_end) && $stable(m_seq_prob)))
        else $error("stalled result transfer changed");

endmodule

bind greedy_sequence_label_decoder_unit gslbd_checker u_gslbd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_char_valid (m_char_valid),
    .m_char_id    (m_char_id),
    .m_seq_end    (m_seq_end),
    .m_seq_prob   (m_seq_prob)
);
